FILE: rtl/qle_pkg.sv
// Shared types, constants and helpers of the tabular Q-learning engine.
`default_nettype none

package qle_pkg;

   // Default table geometry
   localparam int QLE_NUM_STATES  = 16;
   localparam int QLE_MAX_ACTIONS = 4;

   // Configuration port geometry
   localparam int QLE_CSR_AW = 4;
   localparam int QLE_CSR_DW = 32;

   // Register indexes (byte address is four times the index)
   localparam logic [1:0] QLE_REG_LEARN_RATE     = 2'd0;
   localparam logic [1:0] QLE_REG_DISCOUNT       = 2'd1;
   localparam logic [1:0] QLE_REG_EXPLORE_THRESH = 2'd2;
   localparam logic [1:0] QLE_REG_ACTIONS_IN_USE = 2'd3;

   // Register reset values
   localparam logic [15:0] QLE_RST_LEARN_RATE     = 16'd6554;
   localparam logic [15:0] QLE_RST_DISCOUNT       = 16'd58982;
   localparam logic [15:0] QLE_RST_EXPLORE_THRESH = 16'd655;
   localparam logic [2:0]  QLE_RST_ACTIONS_IN_USE = 3'd3;

   // Operation codes
   localparam logic [1:0] QLE_OP_WRITE  = 2'd0;
   localparam logic [1:0] QLE_OP_SELECT = 2'd1;
   localparam logic [1:0] QLE_OP_UPDATE = 2'd2;

   // Configuration handed from the register file to the sequencer
   typedef struct packed {
      logic [15:0] learn_rate;
      logic [15:0] discount;
      logic [15:0] explore_threshold;
      logic [2:0]  actions_in_use;
   } cfg_type;

   // Reduce a small value modulo a small modulus by repeated compare and subtract.
   // Eight steps cover every value below 256 for a modulus of at least 32,
   // and every value below 16 for a modulus of at least 2.
   function automatic logic [7:0] qle_mod_small(input logic [7:0] value,
                                                input logic [8:0] modulus);
      logic [8:0] rem;
      rem = {1'b0, value};
      for (int i = 0; i < 8; i++) begin
         if (rem >= modulus) begin
            rem = rem - modulus;
         end
      end
      return rem[7:0];
   endfunction

endpackage

`default_nettype wire

FILE: rtl/qle_channels.sv
// Request and response channel interfaces of the tabular Q-learning engine.
`default_nettype none

interface qle_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [3:0]  cur_state;
   logic [1:0]  act;
   logic [15:0] entry_value;
   logic [12:0] reward;
   logic [3:0]  next_state;
   logic [15:0] random_draw;
   logic [1:0]  random_action;

   modport source (
      output valid, op, cur_state, act, entry_value, reward, next_state,
             random_draw, random_action,
      input  ready
   );

   modport sink (
      input  valid, op, cur_state, act, entry_value, reward, next_state,
             random_draw, random_action,
      output ready
   );
endinterface

interface qle_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  chosen_action;
   logic        explored;
   logic [15:0] result_value;

   modport source (
      output valid, chosen_action, explored, result_value,
      input  ready
   );

   modport sink (
      input  valid, chosen_action, explored, result_value,
      output ready
   );
endinterface

`default_nettype wire

FILE: rtl/qle_csr.sv
// APB-style register file holding the learning and exploration settings.
`default_nettype none

module qle_csr import qle_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [QLE_CSR_AW-1:0] paddr,
   input  wire logic [QLE_CSR_DW-1:0] pwdata,
   output logic      [QLE_CSR_DW-1:0] prdata,
   output logic                       pready,
   output cfg_type                    cfg
);

   logic [15:0] learn_rate_ff, learn_rate_in;
   logic [15:0] discount_ff, discount_in;
   logic [15:0] thresh_ff, thresh_in;
   logic [2:0]  aiu_ff, aiu_in;
   logic        wr_en;
   logic [1:0]  reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[QLE_CSR_AW-1:2];

   // Decode the access phase of a write transaction
   always_comb begin
      learn_rate_in = learn_rate_ff;
      discount_in   = discount_ff;
      thresh_in     = thresh_ff;
      aiu_in        = aiu_ff;
      if (wr_en) begin
         case (reg_idx)
            QLE_REG_LEARN_RATE:     learn_rate_in = pwdata[15:0];
            QLE_REG_DISCOUNT:       discount_in   = pwdata[15:0];
            QLE_REG_EXPLORE_THRESH: thresh_in     = pwdata[15:0];
            QLE_REG_ACTIONS_IN_USE: aiu_in        = pwdata[2:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         learn_rate_ff <= QLE_RST_LEARN_RATE;
         discount_ff   <= QLE_RST_DISCOUNT;
         thresh_ff     <= QLE_RST_EXPLORE_THRESH;
         aiu_ff        <= QLE_RST_ACTIONS_IN_USE;
      end else begin
         learn_rate_ff <= learn_rate_in;
         discount_ff   <= discount_in;
         thresh_ff     <= thresh_in;
         aiu_ff        <= aiu_in;
      end
   end

   // Return the addressed register on reads
   always_comb begin
      case (reg_idx)
         QLE_REG_LEARN_RATE:     prdata = QLE_CSR_DW'(learn_rate_ff);
         QLE_REG_DISCOUNT:       prdata = QLE_CSR_DW'(discount_ff);
         QLE_REG_EXPLORE_THRESH: prdata = QLE_CSR_DW'(thresh_ff);
         QLE_REG_ACTIONS_IN_USE: prdata = QLE_CSR_DW'(aiu_ff);
         default:                prdata = '0;
      endcase
   end

   assign cfg.learn_rate        = learn_rate_ff;
   assign cfg.discount          = discount_ff;
   assign cfg.explore_threshold = thresh_ff;
   assign cfg.actions_in_use    = aiu_ff;

endmodule

`default_nettype wire

FILE: rtl/qle_table.sv
// Q-table storage: one write port and one read port with registered read data.
`default_nettype none

module qle_table import qle_pkg::*; #(
   parameter int DEPTH  = QLE_NUM_STATES * QLE_MAX_ACTIONS,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [15:0]       wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [15:0]       rd_data
);

   logic [15:0] mem [DEPTH];
   logic [15:0] rd_data_ff;

   // Write the entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read every cycle, data registered and valid in the next cycle
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/qle_ctrl.sv
// Sequencer: row scan, epsilon-greedy choice and the fixed-point Q update.
`default_nettype none

module qle_ctrl import qle_pkg::*; #(
   parameter int NUM_STATES  = QLE_NUM_STATES,
   parameter int MAX_ACTIONS = QLE_MAX_ACTIONS,
   localparam int ADDR_W = $clog2(NUM_STATES * MAX_ACTIONS)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cfg_type           cfg,
   qle_req_if.sink                req,
   qle_rsp_if.source              rsp,
   output logic                   tbl_wr_en,
   output logic      [ADDR_W-1:0] tbl_wr_addr,
   output logic      [15:0]       tbl_wr_data,
   output logic      [ADDR_W-1:0] tbl_rd_addr,
   input  wire logic [15:0]       tbl_rd_data
);

   localparam int SW         = $clog2(NUM_STATES);
   localparam int USED_LIMIT = (MAX_ACTIONS > 7) ? 7 : MAX_ACTIONS;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_QRD  = 3'd2;
   localparam logic [2:0] S_QDAT = 3'd3;
   localparam logic [2:0] S_MUL1 = 3'd4;
   localparam logic [2:0] S_MUL2 = 3'd5;
   localparam logic [2:0] S_RESP = 3'd6;

   // Control state
   logic [2:0]  state_ff, state_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        dv_ff, dv_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // Item and datapath state
   logic [1:0]    op_ff, op_in;
   logic [SW-1:0] row_ff, row_in;
   logic [SW-1:0] scan_row_ff, scan_row_in;
   logic [3:0]    col_ff, col_in;
   logic [12:0]   reward_ff, reward_in;
   logic [2:0]    dcol_ff, dcol_in;
   logic [15:0]   best_ff, best_in;
   logic [2:0]    bcol_ff, bcol_in;
   logic [15:0]   q_ff, q_in;
   logic [15:0]   gm_ff, gm_in;
   logic [32:0]   p1_ff, p1_in;
   logic [16:0]   t_ff, t_in;
   logic [1:0]    res_act_ff, res_act_in;
   logic          res_exp_ff, res_exp_in;
   logic [15:0]   res_val_ff, res_val_in;
   logic [1:0]    out_act_ff, out_act_in;
   logic          out_exp_ff, out_exp_in;
   logic [15:0]   out_val_ff, out_val_in;

   // Combinational helpers
   logic [2:0]    n_used;
   logic [SW-1:0] cur_red, next_red;
   logic [3:0]    act_red, pick;
   logic          explore;
   logic          load;
   logic [31:0]   gm_prod;
   logic [16:0]   keep_rate;
   logic [32:0]   p1_prod;
   logic [32:0]   mix_prod;
   logic [33:0]   acc_sum;
   logic [17:0]   acc_shift;
   logic [15:0]   acc_sat;
   logic [7:0]    cur_mod, next_mod, act_mod, pick_mod;

   function automatic logic [ADDR_W-1:0] addr_of(input logic [SW-1:0] row,
                                                 input logic [3:0]    col);
      return ADDR_W'(int'(row) * MAX_ACTIONS + int'(col));
   endfunction

   // Clamp the action count into one to the table width, capped at seven
   always_comb begin
      if (cfg.actions_in_use == 3'd0) begin
         n_used = 3'd1;
      end else if (int'(cfg.actions_in_use) > USED_LIMIT) begin
         n_used = 3'(USED_LIMIT);
      end else begin
         n_used = cfg.actions_in_use;
      end
   end

   // Reduce incoming indexes into the table
   assign cur_mod  = qle_mod_small(8'(req.cur_state), 9'(NUM_STATES));
   assign next_mod = qle_mod_small(8'(req.next_state), 9'(NUM_STATES));
   assign act_mod  = qle_mod_small(8'(req.act), 9'(MAX_ACTIONS));
   assign pick_mod = qle_mod_small(8'(req.random_action), 9'(n_used));
   assign cur_red  = cur_mod[SW-1:0];
   assign next_red = next_mod[SW-1:0];
   assign act_red  = act_mod[3:0];
   assign pick     = pick_mod[3:0];
   assign explore  = req.random_draw < cfg.explore_threshold;

   // Update arithmetic, one multiplier per stage
   assign gm_prod   = 32'(cfg.discount) * 32'(best_ff);
   assign keep_rate = 17'h10000 - 17'(cfg.learn_rate);
   assign p1_prod   = 33'(keep_rate) * 33'(q_ff);
   assign mix_prod  = 33'(cfg.learn_rate) * 33'(t_ff);
   assign acc_sum   = 34'(p1_ff) + 34'(mix_prod);
   assign acc_shift = acc_sum[33:16];
   assign acc_sat   = (|acc_shift[17:16]) ? 16'hFFFF : acc_shift[15:0];

   assign req.ready = (state_ff == S_IDLE);

   // Sequence one transaction through the scan, read, multiply and respond states its op needs
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      dv_in       = dv_ff;
      op_in       = op_ff;
      row_in      = row_ff;
      scan_row_in = scan_row_ff;
      col_in      = col_ff;
      reward_in   = reward_ff;
      dcol_in     = dcol_ff;
      best_in     = best_ff;
      bcol_in     = bcol_ff;
      q_in        = q_ff;
      gm_in       = gm_ff;
      p1_in       = p1_ff;
      t_in        = t_ff;
      res_act_in  = res_act_ff;
      res_exp_in  = res_exp_ff;
      res_val_in  = res_val_ff;
      load        = 1'b0;
      tbl_wr_en   = 1'b0;
      tbl_rd_addr = addr_of(row_ff, col_ff);

      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               op_in      = req.op;
               row_in     = cur_red;
               reward_in  = req.reward;
               cnt_in     = 3'd0;
               dv_in      = 1'b0;
               res_act_in = 2'd0;
               res_exp_in = 1'b0;
               res_val_in = 16'd0;
               case (req.op)
                  QLE_OP_WRITE: begin
                     col_in     = act_red;
                     res_val_in = req.entry_value;
                     state_in   = S_RESP;
                  end
                  QLE_OP_SELECT: begin
                     if (explore) begin
                        col_in   = pick;
                        state_in = S_QRD;
                     end else begin
                        scan_row_in = cur_red;
                        state_in    = S_SCAN;
                     end
                  end
                  QLE_OP_UPDATE: begin
                     col_in      = act_red;
                     scan_row_in = next_red;
                     state_in    = S_SCAN;
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end

         S_SCAN: begin
            // Issue one column read per cycle
            tbl_rd_addr = addr_of(scan_row_ff, {1'b0, cnt_ff});
            if (cnt_ff != n_used) begin
               cnt_in  = cnt_ff + 3'd1;
               dv_in   = 1'b1;
               dcol_in = cnt_ff;
            end else begin
               dv_in = 1'b0;
            end
            // Keep the first maximum
            if (dv_ff && ((dcol_ff == 3'd0) || (tbl_rd_data > best_ff))) begin
               best_in = tbl_rd_data;
               bcol_in = dcol_ff;
            end
            if ((cnt_ff == n_used) && !dv_ff) begin
               if (op_ff == QLE_OP_SELECT) begin
                  res_act_in = bcol_ff[1:0];
                  res_val_in = best_ff;
                  state_in   = S_RESP;
               end else begin
                  state_in = S_QRD;
               end
            end
         end

         S_QRD: begin
            state_in = S_QDAT;
         end

         S_QDAT: begin
            q_in = tbl_rd_data;
            if (op_ff == QLE_OP_SELECT) begin
               res_act_in = col_ff[1:0];
               res_exp_in = 1'b1;
               res_val_in = tbl_rd_data;
               state_in   = S_RESP;
            end else begin
               gm_in    = gm_prod[31:16];
               state_in = S_MUL1;
            end
         end

         S_MUL1: begin
            p1_in    = p1_prod;
            t_in     = 17'(reward_ff) + 17'(gm_ff);
            state_in = S_MUL2;
         end

         S_MUL2: begin
            res_val_in = acc_sat;
            state_in   = S_RESP;
         end

         S_RESP: begin
            // Hand over once the output register is free, write back at the same edge
            if (!rsp_valid_ff || rsp.ready) begin
               load      = 1'b1;
               tbl_wr_en = (op_ff == QLE_OP_WRITE) || (op_ff == QLE_OP_UPDATE);
               state_in  = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   assign tbl_wr_addr = addr_of(row_ff, col_ff);
   assign tbl_wr_data = res_val_ff;

   // Output register
   assign rsp_valid_in = load | (rsp_valid_ff & ~rsp.ready);
   assign out_act_in   = load ? res_act_ff : out_act_ff;
   assign out_exp_in   = load ? res_exp_ff : out_exp_ff;
   assign out_val_in   = load ? res_val_ff : out_val_ff;

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.chosen_action = out_act_ff;
   assign rsp.explored      = out_exp_ff;
   assign rsp.result_value  = out_val_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= 3'd0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      row_ff      <= row_in;
      scan_row_ff <= scan_row_in;
      col_ff      <= col_in;
      reward_ff   <= reward_in;
      dcol_ff     <= dcol_in;
      best_ff     <= best_in;
      bcol_ff     <= bcol_in;
      q_ff        <= q_in;
      gm_ff       <= gm_in;
      p1_ff       <= p1_in;
      t_ff        <= t_in;
      res_act_ff  <= res_act_in;
      res_exp_ff  <= res_exp_in;
      res_val_ff  <= res_val_in;
      out_act_ff  <= out_act_in;
      out_exp_ff  <= out_exp_in;
      out_val_ff  <= out_val_in;
   end

endmodule

`default_nettype wire

FILE: rtl/tabular_q_learning_engine.sv
// Top level of the tabular Q-learning engine.
//
//   channel   direction  handshake             carries
//   req       in         req.valid/req.ready   op, states, action, value, reward, draws
//   rsp       out        rsp.valid/rsp.ready   chosen_action, explored, result_value
//   csr       in         APB psel/penable      learn_rate, discount, threshold, actions
//
// One transaction at a time; n is the clamped number of actions in use.
// A write or unused op goes straight to the response; an explore select reads
// the drawn entry; a greedy select reads the n columns of its row in turn; an
// update scans the next state's row, reads the entry, then runs the multiplies.
// A new request is taken the cycle after the result enters the output register,
// even while that result still waits on rsp.ready.
// Reset restores the registers; the table holds no valid data until written.
`default_nettype none

module tabular_q_learning_engine import qle_pkg::*; #(
   parameter int NUM_STATES  = QLE_NUM_STATES,
   parameter int MAX_ACTIONS = QLE_MAX_ACTIONS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   qle_req_if.sink                    req,
   qle_rsp_if.source                  rsp,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [QLE_CSR_AW-1:0] csr_paddr,
   input  wire logic [QLE_CSR_DW-1:0] csr_pwdata,
   output logic      [QLE_CSR_DW-1:0] csr_prdata,
   output logic                       csr_pready
);

   localparam int DEPTH  = NUM_STATES * MAX_ACTIONS;
   localparam int ADDR_W = $clog2(DEPTH);

   cfg_type           cfg;
   logic              tbl_wr_en;
   logic [ADDR_W-1:0] tbl_wr_addr;
   logic [15:0]       tbl_wr_data;
   logic [ADDR_W-1:0] tbl_rd_addr;
   logic [15:0]       tbl_rd_data;

   qle_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   qle_table #(
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   qle_ctrl #(
      .NUM_STATES  (NUM_STATES),
      .MAX_ACTIONS (MAX_ACTIONS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req         (req),
      .rsp         (rsp),
      .tbl_wr_en   (tbl_wr_en),
      .tbl_wr_addr (tbl_wr_addr),
      .tbl_wr_data (tbl_wr_data),
      .tbl_rd_addr (tbl_rd_addr),
      .tbl_rd_data (tbl_rd_data)
   );

endmodule

`default_nettype wire

FILE: rtl/qle_checker.sv
// Port-level checks of the tabular Q-learning engine and their binding.
`default_nettype none

module qle_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_chosen_action,
   input wire logic        rsp_explored,
   input wire logic [15:0] rsp_result_value
);

   logic [1:0] pending_ff, pending_in;
   logic       req_xfer, rsp_xfer;

   assign req_xfer = req_valid & req_ready;
   assign rsp_xfer = rsp_valid & rsp_ready;

   // Track transactions accepted but not yet answered
   always_comb begin
      pending_in = pending_ff;
      if (req_xfer && !rsp_xfer) begin
         pending_in = pending_ff + 2'd1;
      end else if (!req_xfer && rsp_xfer) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 2'd0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_ready)
      else $error("request taken while previous transaction still in work");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pending_ff != 2'd0))
      else $error("response without an accepted request");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("more than two transactions in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value)
         && $stable(rsp_chosen_action) && $stable(rsp_explored))
      else $error("stalled response changed");

endmodule

bind tabular_q_learning_engine qle_checker u_qle_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req.valid),
   .req_ready         (req.ready),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_chosen_action (rsp.chosen_action),
   .rsp_explored      (rsp.explored),
   .rsp_result_value  (rsp.result_value)
);

`default_nettype wire
